/* sv/lphm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg: shared definitions of the linear probe hash map
// widths, operation and status codes, slot marks, row layout and key fold
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int CAPACITY   = 1024;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 11;
  localparam int KIND_BITS  = 2;
  localparam int STAT_BITS  = 2;
  localparam int MARK_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] MAX_RESET = COUNT_BITS'(614);
  localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

  localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd3;

  localparam logic [STAT_BITS-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_FULL   = 2'd2;

  localparam logic [MARK_BITS-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_BITS-1:0] MARK_LIVE  = 2'd1;
  localparam logic [MARK_BITS-1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [MARK_BITS-1:0]  mark;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } row_t;

  localparam int ROW_BITS = $bits(row_t);

  function automatic logic [IDX_BITS-1:0] home_slot(input logic [KEY_BITS-1:0] key);
    logic [63:0] k;
    k = 64'(key);
    k = k ^ (k >> 32);
    k = k ^ (k >> 16);
    return k[IDX_BITS-1:0];
  endfunction

endpackage

/* sv/lphm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_if: request and response channels of the linear probe hash map
// valid/ready handshake with the operation or its result as payload
// ----------------------------------------------------------------------------
interface lphm_req_if;
  import lphm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lphm_rsp_if;
  import lphm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_BITS-1:0]  status;
  logic [VALUE_BITS-1:0] found_value;
  logic [COUNT_BITS-1:0] entry_count;

  modport source (output valid, output status, output found_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_value, input entry_count,
                  output ready);
endinterface

/* sv/lphm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/linear_probe_hash_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map: open addressing key/value table, linear probing
// lookup, insert or update, and remove with tombstones over one slot ram
// ----------------------------------------------------------------------------
// channel  dir  payload                                  handshake
// req_i    in   kind, key, value                         valid/ready
// rsp_o    out  status, found_value, entry_count         valid/ready
// cfg      in   cfg_wdata_i = max_entries                cfg_we_i
//
// an operation probes p slots (1..1024, 0 for key zero or the unused kind):
// one slot ram read per cycle sets the probe rate
// after reset a clearing pass marks every slot empty,
// no request is taken meanwhile
// a finished result waits in the output register; the next request is
// taken while it waits, its own result holds until the register frees
// ----------------------------------------------------------------------------
module linear_probe_hash_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lphm_pkg::COUNT_BITS-1:0] cfg_wdata_i,
  lphm_req_if.sink                        req_i,
  lphm_rsp_if.source                      rsp_o
);
  import lphm_pkg::*;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);

  logic [1:0]            state_q, state_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [IDX_BITS-1:0]   n_q, n_d;
  logic [IDX_BITS-1:0]   room_q, room_d;
  logic                  room_vld_q, room_vld_d;
  logic [IDX_BITS-1:0]   clr_q, clr_d;
  logic [KIND_BITS-1:0]  kind_q, kind_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [COUNT_BITS-1:0] live_q, live_d;
  logic [COUNT_BITS-1:0] max_q, max_d;
  logic [STAT_BITS-1:0]  res_stat_q, res_stat_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;
  logic                  rsp_vld_q, rsp_vld_d;
  logic [STAT_BITS-1:0]  rsp_stat_q, rsp_stat_d;
  logic [VALUE_BITS-1:0] rsp_val_q, rsp_val_d;
  logic [COUNT_BITS-1:0] rsp_cnt_q, rsp_cnt_d;

  logic                  ram_we;
  logic [IDX_BITS-1:0]   ram_waddr;
  row_t                  ram_wdata;
  logic [IDX_BITS-1:0]   ram_raddr;
  logic [ROW_BITS-1:0]   ram_rdata;
  row_t                  row;

  logic req_fire;
  logic is_empty, is_live, is_hit, last, stop, room_ok, full;
  logic [IDX_BITS-1:0] room_sel;

  lphm_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row       = row_t'(ram_rdata);
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire  = req_i.valid && req_i.ready;

  assign is_empty = (row.mark == MARK_EMPTY);
  assign is_live  = (row.mark == MARK_LIVE);
  assign is_hit   = is_live && (row.key == key_q);
  assign last     = (n_q == LAST_IDX);
  assign stop     = is_empty || is_hit || last;
  assign room_sel = room_vld_q ? room_q : idx_q;
  assign room_ok  = room_vld_q || !is_live;
  assign full     = (live_q >= max_q) || (live_q >= CAP_COUNT) || !room_ok;

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_stat_q;
  assign rsp_o.found_value = rsp_val_q;
  assign rsp_o.entry_count = rsp_cnt_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    room_d     = room_q;
    room_vld_d = room_vld_q;
    clr_d      = clr_q;
    kind_d     = kind_q;
    key_d      = key_q;
    value_d    = value_q;
    live_d     = live_q;
    max_d      = cfg_we_i ? cfg_wdata_i : max_q;
    res_stat_d = res_stat_q;
    res_val_d  = res_val_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    rsp_stat_d = rsp_stat_q;
    rsp_val_d  = rsp_val_q;
    rsp_cnt_d  = rsp_cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = '{mark: MARK_LIVE, key: key_q, value: value_q};
    ram_raddr  = idx_q + 1'b1;

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '{mark: MARK_EMPTY, key: '0, value: '0};
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = home_slot(req_i.key);
        if (req_fire) begin
          kind_d     = req_i.kind;
          key_d      = req_i.key;
          value_d    = req_i.value;
          idx_d      = home_slot(req_i.key);
          n_d        = '0;
          room_vld_d = 1'b0;
          if (req_i.key == '0 || req_i.kind == KIND_NONE) begin
            res_stat_d = STAT_ABSENT;
            res_val_d  = '0;
            state_d    = S_DONE;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (stop) begin
          res_stat_d = STAT_ABSENT;
          res_val_d  = '0;
          state_d    = S_DONE;
          unique case (kind_q)
            KIND_LOOKUP: begin
              if (is_hit) begin
                res_stat_d = STAT_OK;
                res_val_d  = row.value;
              end
            end
            KIND_INSERT: begin
              if (is_hit) begin
                ram_we     = 1'b1;
                res_stat_d = STAT_OK;
              end else if (full) begin
                res_stat_d = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = room_sel;
                live_d     = live_q + 1'b1;
                res_stat_d = STAT_OK;
              end
            end
            KIND_REMOVE: begin
              if (is_hit) begin
                ram_we     = 1'b1;
                ram_wdata  = '{mark: MARK_TOMB, key: '0, value: '0};
                live_d     = (live_q != '0) ? live_q - 1'b1 : live_q;
                res_stat_d = STAT_OK;
              end
            end
            default: begin
              res_stat_d = STAT_ABSENT;
            end
          endcase
        end else begin
          idx_d = idx_q + 1'b1;
          n_d   = n_q + 1'b1;
          if (!room_vld_q && !is_live) begin
            room_d     = idx_q;
            room_vld_d = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d  = 1'b1;
          rsp_stat_d = res_stat_q;
          rsp_val_d  = res_val_q;
          rsp_cnt_d  = live_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      clr_q      <= '0;
      live_q     <= '0;
      max_q      <= MAX_RESET;
      rsp_vld_q  <= 1'b0;
      room_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      live_q     <= live_d;
      max_q      <= max_d;
      rsp_vld_q  <= rsp_vld_d;
      room_vld_q <= room_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    n_q        <= n_d;
    room_q     <= room_d;
    kind_q     <= kind_d;
    key_q      <= key_d;
    value_q    <= value_d;
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    rsp_stat_q <= rsp_stat_d;
    rsp_val_q  <= rsp_val_d;
    rsp_cnt_q  <= rsp_cnt_d;
  end

`ifndef NO_ASSERTIONS
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.entry_count <= CAP_COUNT))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(live_q) |-> ((live_q == $past(live_q) + 1'b1) ||
                          (live_q == $past(live_q) - 1'b1)))
    else $error("live count moved by more than one");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != STAT_OK) |-> (rsp_o.found_value == '0))
    else $error("found value set on a failed request");

  a_write_only_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_INIT) |-> (state_q == S_LOOK && stop))
    else $error("slot write outside the end of a probe");
`endif

endmodule
